/* sv/mss_pkg.sv */
`default_nettype none

package mss_pkg;

    localparam int POS_BITS = 10;
    localparam int LEN_BITS = 11;
    localparam int OUT_BITS = 40;

    localparam int DEFAULT_LEAF_COUNT = 1024;
    localparam int DEFAULT_VALUE_BITS = 31;

    localparam logic [LEN_BITS-1:0] LEN_RESET = 11'd1024;
    localparam logic [63:0] OUT_MAX = (64'd1 << OUT_BITS) - 64'd1;

endpackage

`default_nettype wire

/* sv/mss_merge.sv */
`default_nettype none

module mss_merge #(
    parameter int NODE_BITS = 42
) (
    input  wire logic [4*NODE_BITS-1:0] left,
    input  wire logic [4*NODE_BITS-1:0] right,
    output logic      [4*NODE_BITS-1:0] parent
);

    typedef struct packed {
        logic signed [NODE_BITS-1:0] total;
        logic signed [NODE_BITS-1:0] prefix;
        logic signed [NODE_BITS-1:0] suffix;
        logic signed [NODE_BITS-1:0] span;
    } node_t;

    node_t l;
    node_t r;
    node_t p;
    logic signed [NODE_BITS-1:0] pre_cross;
    logic signed [NODE_BITS-1:0] suf_cross;
    logic signed [NODE_BITS-1:0] mid_cross;
    logic signed [NODE_BITS-1:0] span_side;

    assign l = node_t'(left);
    assign r = node_t'(right);

    always_comb
    begin
        pre_cross = l.total + r.prefix;
        suf_cross = r.total + l.suffix;
        mid_cross = l.suffix + r.prefix;
        span_side = (l.span > r.span) ? l.span : r.span;

        p.total  = l.total + r.total;
        p.prefix = (l.prefix > pre_cross) ? l.prefix : pre_cross;
        p.suffix = (r.suffix > suf_cross) ? r.suffix : suf_cross;
        p.span   = (span_side > mid_cross) ? span_side : mid_cross;
    end

    assign parent = p;

endmodule

`default_nettype wire

/* sv/max_subarray_segment_tree.sv */
// Channel      Signals                                  Transaction
// -----------  ---------------------------------------  ------------------------------
// update in    start, busy, position, new_value         start && !busy
// result out   done, best_sum                           done (one cycle, no stall)
// config       cfg_valid, cfg_ready, array_length       cfg_valid && cfg_ready
//
// An update in use writes the leaf, then walks up the tree one level per step,
// each step reading the sibling from the node memory's single read port.
// An unused position gives done in the cycle after acceptance.
// After reset a clearing pass writes all 2*LEAF_COUNT nodes, one per cycle,
// with busy high; configuration writes are taken at all times.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module max_subarray_segment_tree
    import mss_pkg::*;
#(
    parameter int LEAF_COUNT = DEFAULT_LEAF_COUNT,
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic        [POS_BITS-1:0]   position,
    input  wire logic signed [VALUE_BITS-1:0] new_value,
    output logic                              done,
    output logic             [OUT_BITS-1:0]   best_sum,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic        [LEN_BITS-1:0]   array_length
);

    localparam int LEAF_BITS = $clog2(LEAF_COUNT);
    localparam int IDX_BITS  = LEAF_BITS + 1;
    localparam int NODE_BITS = VALUE_BITS + LEAF_BITS + 1;
    localparam int NODE_W    = 4 * NODE_BITS;
    localparam int NODE_NUM  = 2 * LEAF_COUNT;

    typedef struct packed {
        logic signed [NODE_BITS-1:0] total;
        logic signed [NODE_BITS-1:0] prefix;
        logic signed [NODE_BITS-1:0] suffix;
        logic signed [NODE_BITS-1:0] span;
    } node_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LEAF,
        S_WALK
    } state_t;

    state_t                state_reg, state_next;
    logic [IDX_BITS-1:0]   clr_reg, clr_next;
    logic [IDX_BITS-1:0]   node_reg, node_next;
    node_t                 cur_reg, cur_next;
    logic                  done_reg, done_next;
    logic [OUT_BITS-1:0]   best_sum_reg, best_sum_next;
    logic [OUT_BITS-1:0]   root_best_reg, root_best_next;
    logic [LEN_BITS-1:0]   length_reg;

    logic [NODE_W-1:0]     mem [NODE_NUM];
    logic [NODE_W-1:0]     rdata_reg;
    logic                  mem_we;
    logic [IDX_BITS-1:0]   mem_waddr;
    logic [IDX_BITS-1:0]   mem_raddr;
    logic [NODE_W-1:0]     mem_wdata;

    logic                  accept;
    logic                  in_use;
    logic [IDX_BITS-1:0]   parent_idx;
    logic [IDX_BITS-1:0]   leaf_idx;
    node_t                 leaf_node;
    logic signed [NODE_BITS-1:0] value_ext;
    node_t                 sib_node;
    logic [NODE_W-1:0]     merge_left;
    logic [NODE_W-1:0]     merge_right;
    logic [NODE_W-1:0]     merge_out;
    node_t                 merged;
    logic [63:0]           span_wide;
    logic [OUT_BITS-1:0]   span_sat;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign best_sum  = best_sum_reg;

    assign accept = start && !busy;
    assign in_use = ({1'b0, position} < length_reg) && (32'(position) < LEAF_COUNT);

    assign leaf_idx   = IDX_BITS'(LEAF_COUNT) + IDX_BITS'(position);
    assign parent_idx = node_reg >> 1;

    assign value_ext        = NODE_BITS'(new_value);
    assign leaf_node.total  = value_ext;
    assign leaf_node.prefix = new_value[VALUE_BITS-1] ? '0 : value_ext;
    assign leaf_node.suffix = new_value[VALUE_BITS-1] ? '0 : value_ext;
    assign leaf_node.span   = new_value[VALUE_BITS-1] ? '0 : value_ext;

    assign sib_node    = node_t'(rdata_reg);
    assign merge_left  = node_reg[0] ? NODE_W'(sib_node) : NODE_W'(cur_reg);
    assign merge_right = node_reg[0] ? NODE_W'(cur_reg) : NODE_W'(sib_node);

    mss_merge #(
        .NODE_BITS (NODE_BITS)
    ) u_merge (
        .left   (merge_left),
        .right  (merge_right),
        .parent (merge_out)
    );

    assign merged    = node_t'(merge_out);
    assign span_wide = 64'($unsigned(merged.span));
    assign span_sat  = (span_wide > OUT_MAX) ? OUT_BITS'(OUT_MAX) : OUT_BITS'(span_wide);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = clr_reg;
        mem_raddr = '0;
        mem_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
            end
            S_LEAF:
            begin
                mem_we    = 1'b1;
                mem_waddr = node_reg;
                mem_wdata = cur_reg;
                mem_raddr = node_reg ^ IDX_BITS'(1);
            end
            S_WALK:
            begin
                mem_we    = 1'b1;
                mem_waddr = parent_idx;
                mem_wdata = merged;
                mem_raddr = parent_idx ^ IDX_BITS'(1);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        node_next      = node_reg;
        cur_next       = cur_reg;
        done_next      = 1'b0;
        best_sum_next  = best_sum_reg;
        root_best_next = root_best_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + IDX_BITS'(1);
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_use)
                    begin
                        node_next  = leaf_idx;
                        cur_next   = leaf_node;
                        state_next = S_LEAF;
                    end
                    else
                    begin
                        done_next     = 1'b1;
                        best_sum_next = root_best_reg;
                    end
                end
            end
            S_LEAF:
            begin
                state_next = S_WALK;
            end
            S_WALK:
            begin
                node_next = parent_idx;
                cur_next  = merged;
                if (parent_idx == IDX_BITS'(1))
                begin
                    done_next      = 1'b1;
                    best_sum_next  = span_sat;
                    root_best_next = span_sat;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            done_reg      <= 1'b0;
            root_best_reg <= '0;
            best_sum_reg  <= '0;
            node_reg      <= '0;
            cur_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            done_reg      <= done_next;
            root_best_reg <= root_best_next;
            best_sum_reg  <= best_sum_next;
            node_reg      <= node_next;
            cur_reg       <= cur_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            length_reg <= array_length;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == S_IDLE))
        else $error("result strobe outside idle state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LEAF || state_reg == S_WALK) |-> (mem_waddr != mem_raddr))
        else $error("node memory read and write hit the same entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (node_reg >= IDX_BITS'(2)))
        else $error("tree walk below the root");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_use) |=> (busy && !done))
        else $error("update in use did not start a tree walk");

endmodule

`default_nettype wire

/* bench/tb_max_subarray_segment_tree.sv */
module tb_max_subarray_segment_tree
    import mss_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEAVES      = DEFAULT_LEAF_COUNT;
    localparam int VALUE_BITS  = DEFAULT_VALUE_BITS;
    localparam int STALL_LIMIT = 10000;
    localparam int TAIL_CYCLES = 40;

    localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    typedef enum logic [1:0] {
        OP_UPDATE,
        OP_CONFIG,
        OP_DRAIN
    } op_kind_e;

    typedef enum logic [1:0] {
        DRV_FETCH,
        DRV_GAP,
        DRV_UPD,
        DRV_CFG
    } drv_state_e;

    typedef struct {
        op_kind_e                       kind;
        logic        [POS_BITS-1:0]     pos;
        logic signed [VALUE_BITS-1:0]   value;
        logic        [LEN_BITS-1:0]     length;
        int                             gap;
    } pending_op_t;

    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           start        = 1'b0;
    logic                           busy;
    logic        [POS_BITS-1:0]     position     = '0;
    logic signed [VALUE_BITS-1:0]   new_value    = '0;
    logic                           done;
    logic        [OUT_BITS-1:0]     best_sum;
    logic                           cfg_valid    = 1'b0;
    logic                           cfg_ready;
    logic        [LEN_BITS-1:0]     array_length = '0;

    pending_op_t                    pending_ops[$];
    pending_op_t                    cur_op;
    logic        [OUT_BITS-1:0]     sums_due[$];

    longint                         seg_total [1:2*LEAVES-1];
    longint                         seg_pre   [1:2*LEAVES-1];
    longint                         seg_suf   [1:2*LEAVES-1];
    longint                         seg_span  [1:2*LEAVES-1];
    logic        [LEN_BITS-1:0]     len_model = LEN_RESET;

    drv_state_e                     drv_state = DRV_FETCH;
    int                             gap_left;
    int                             upd_acc, upd_seen, cfg_acc, cfg_seen;
    int                             skipped_updates, results_checked, errors, stall_cycles;
    logic                           nxt_start, nxt_cfg_valid;
    logic        [OUT_BITS-1:0]     exp_sum;

    max_subarray_segment_tree i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .position     (position),
        .new_value    (new_value),
        .done         (done),
        .best_sum     (best_sum),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .array_length (array_length)
    );

    always #4ns clk = ~clk;

    function automatic longint pick_max(input longint a, input longint b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic [OUT_BITS-1:0] apply_update(
        input logic        [POS_BITS-1:0]   pos,
        input logic signed [VALUE_BITS-1:0] val
    );
        int     k;
        longint lv;
        longint best;
        if (pos < len_model && pos < LEAVES) begin
            k = LEAVES + int'(pos);
            lv = val;
            seg_total[k] = lv;
            seg_pre[k]   = pick_max(0, lv);
            seg_suf[k]   = seg_pre[k];
            seg_span[k]  = seg_pre[k];
            k = k / 2;
            while (k >= 1) begin
                seg_total[k] = seg_total[2*k] + seg_total[2*k+1];
                seg_pre[k]   = pick_max(seg_pre[2*k], seg_total[2*k] + seg_pre[2*k+1]);
                seg_suf[k]   = pick_max(seg_suf[2*k+1], seg_total[2*k+1] + seg_suf[2*k]);
                seg_span[k]  = pick_max(pick_max(seg_span[2*k], seg_span[2*k+1]),
                                        seg_suf[2*k] + seg_pre[2*k+1]);
                k = k / 2;
            end
        end else begin
            skipped_updates++;
        end
        best = pick_max(0, seg_span[1]);
        if (best > longint'(OUT_MAX))
            best = longint'(OUT_MAX);
        return best[OUT_BITS-1:0];
    endfunction

    task automatic queue_op(
        input op_kind_e                     kind,
        input logic        [POS_BITS-1:0]   pos,
        input logic signed [VALUE_BITS-1:0] val,
        input logic        [LEN_BITS-1:0]   len,
        input int                           gap
    );
        pending_op_t op;
        op.kind   = kind;
        op.pos    = pos;
        op.value  = val;
        op.length = len;
        op.gap    = gap;
        pending_ops = {pending_ops, op};
    endtask

    // Monitor, predictor and watchdog: everything is sampled at the rising edge.
    always @(posedge clk) begin
        if (rst_n) begin
            stall_cycles++;
            if (done) begin
                stall_cycles = 0;
                if (sums_due.size() == 0) begin
                    errors++;
                    $display("%0t: result with none pending, expected none, actual %0d",
                             $time, best_sum);
                end else begin
                    exp_sum = sums_due.pop_front();
                    results_checked++;
                    if (best_sum !== exp_sum) begin
                        errors++;
                        $display("%0t: best_sum mismatch, expected %0d, actual %0d",
                                 $time, exp_sum, best_sum);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                len_model = array_length;
                cfg_acc++;
                stall_cycles = 0;
            end
            if (start && !busy) begin
                sums_due = {sums_due, apply_update(position, new_value)};
                upd_acc++;
                stall_cycles = 0;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, stall_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Driver: inputs change at the falling edge only.
    always @(negedge clk) begin
        nxt_start     = start;
        nxt_cfg_valid = cfg_valid;
        if (rst_n) begin
            if (drv_state == DRV_UPD && upd_acc != upd_seen) begin
                upd_seen  = upd_acc;
                nxt_start = 1'b0;
                drv_state = DRV_FETCH;
            end
            if (drv_state == DRV_CFG && cfg_acc != cfg_seen) begin
                cfg_seen      = cfg_acc;
                nxt_cfg_valid = 1'b0;
                drv_state     = DRV_FETCH;
            end
            if (drv_state == DRV_FETCH && pending_ops.size() != 0) begin
                cur_op    = pending_ops.pop_front();
                gap_left  = cur_op.gap;
                drv_state = DRV_GAP;
            end
            if (drv_state == DRV_GAP) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (cur_op.kind == OP_UPDATE) begin
                    nxt_start = 1'b1;
                    position  <= cur_op.pos;
                    new_value <= cur_op.value;
                    drv_state = DRV_UPD;
                end else if (sums_due.size() == 0) begin
                    if (cur_op.kind == OP_CONFIG) begin
                        nxt_cfg_valid = 1'b1;
                        array_length  <= cur_op.length;
                        drv_state     = DRV_CFG;
                    end else begin
                        drv_state = DRV_FETCH;
                    end
                end
            end
        end
        start     <= nxt_start;
        cfg_valid <= nxt_cfg_valid;
    end

    initial begin
        int                           ph, i, lim, gap;
        longint                       lv;
        logic        [LEN_BITS-1:0]   len;
        logic        [POS_BITS-1:0]   pos;
        logic signed [VALUE_BITS-1:0] val;
        logic        [LEN_BITS-1:0]   phase_len [8];

        // Directed: extremes, splits across the midpoint, unused positions.
        queue_op(OP_CONFIG, '0, '0, LEN_RESET, 0);
        queue_op(OP_UPDATE, 10'd0,    VAL_MAX, '0, $urandom_range(0, 6));
        queue_op(OP_UPDATE, 10'd1023, VAL_MAX, '0, $urandom_range(0, 6));
        queue_op(OP_UPDATE, 10'd511,  VAL_MIN, '0, $urandom_range(0, 6));
        queue_op(OP_UPDATE, 10'd511,  '0,      '0, $urandom_range(0, 6));
        queue_op(OP_UPDATE, 10'd0,    VAL_MIN, '0, $urandom_range(0, 6));
        queue_op(OP_UPDATE, 10'd1023, VAL_MIN, '0, $urandom_range(0, 6));
        queue_op(OP_UPDATE, 10'd5,    1000000000,  '0, 0);
        queue_op(OP_UPDATE, 10'd6,    -1,          '0, 0);
        queue_op(OP_UPDATE, 10'd7,    1000000000,  '0, 0);
        queue_op(OP_UPDATE, 10'd6,    -1000000000, '0, 0);
        queue_op(OP_UPDATE, 10'd100,  31'h2AAAAAAA, '0, $urandom_range(0, 6));
        queue_op(OP_UPDATE, 10'd101,  31'h55555555, '0, $urandom_range(0, 6));
        queue_op(OP_CONFIG, '0, '0, 11'd0, 0);
        queue_op(OP_UPDATE, 10'd3,    12345,   '0, $urandom_range(0, 6));
        queue_op(OP_UPDATE, 10'd1023, VAL_MAX, '0, $urandom_range(0, 6));
        queue_op(OP_CONFIG, '0, '0, 11'd1, 0);
        queue_op(OP_UPDATE, 10'd0,    77,      '0, $urandom_range(0, 6));
        queue_op(OP_UPDATE, 10'd1,    99,      '0, $urandom_range(0, 6));
        queue_op(OP_UPDATE, 10'd1023, VAL_MAX, '0, $urandom_range(0, 6));
        queue_op(OP_CONFIG, '0, '0, 11'd2047, 0);
        queue_op(OP_UPDATE, 10'd1023, VAL_MAX, '0, $urandom_range(0, 6));
        queue_op(OP_UPDATE, 10'd0,    VAL_MIN, '0, $urandom_range(0, 6));

        phase_len = '{LEN_RESET, 11'd1, 11'd37, 11'd2047, 11'd0, 11'd700,
                      LEN_BITS'($urandom_range(2, 1023)), LEN_RESET};
        for (ph = 0; ph < 8; ph++) begin
            len = phase_len[ph];
            lim = (len > LEAVES) ? LEAVES : int'(len);
            queue_op(OP_CONFIG, '0, '0, len, $urandom_range(0, 6));
            for (i = 0; i < ((len == 0) ? 20 : 130); i++) begin
                if (lim != 0 && $urandom_range(0, 99) < 85)
                    pos = POS_BITS'($urandom_range(0, lim - 1));
                else
                    pos = POS_BITS'($urandom_range(0, LEAVES - 1));
                case ($urandom_range(0, 9))
                    0:       val = VAL_MIN;
                    1:       val = VAL_MAX;
                    2, 3:    val = VALUE_BITS'($urandom);
                    4, 5, 6: begin
                        lv  = longint'($urandom_range(0, 2000000000)) - 64'sd1000000000;
                        val = lv[VALUE_BITS-1:0];
                    end
                    default: begin
                        lv  = longint'($urandom_range(0, 100)) - 64'sd50;
                        val = lv[VALUE_BITS-1:0];
                    end
                endcase
                gap = (i >= 20 && i < 45) ? 0 : $urandom_range(0, 6);
                queue_op(OP_UPDATE, pos, val, '0, gap);
                // hold the sender until every pending result is back
                if (i == 70)
                    queue_op(OP_DRAIN, '0, '0, '0, 0);
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (!(drv_state == DRV_FETCH && pending_ops.size() == 0 && sums_due.size() == 0))
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d updates (%0d at unused positions), %0d results checked,",
                 upd_acc, skipped_updates, results_checked);
        $display("%0d array_length writes incl. 0, 1, 1024 and 2047; %0d errors",
                 cfg_acc, errors);
        if (errors == 0 && sums_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
